FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_SPARE = 4'b1000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic wrap;
        logic clear_done;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character screen of COLUMNS x ROWS cells with a write cursor; puts store
// at the cursor (a newline put only moves it), reads return one cell.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | in        | i_in_valid / o_in_ready  | action, character, cell_index
//   out     | out       | o_out_valid / i_out_ready| cell_char, cursor_column,
//           |           |                          | cursor_row, screen_cleared
//
// A transaction is captured while the RAM registers the addressed cell,
// then committed into the result register. A new transaction is taken
// while a result waits, but commit holds until the result register is
// free. After reset, and after a put that runs past the last row, a sweep
// writes spaces to all COLUMNS*ROWS cells (2000 by default) through the
// single RAM write port; no input is taken during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_character,
    input  wire logic [10:0] i_cell_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_cell_char,
    output logic [6:0]       o_cursor_column,
    output logic [4:0]       o_cursor_row,
    output logic             o_screen_cleared
);

    t_cmd  cmd;
    t_stat stat;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_action),
        .i_character      (i_character),
        .i_cell_index     (i_cell_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cell_char      (o_cell_char),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_row     (o_cursor_row),
        .o_screen_cleared (o_screen_cleared)
    );

endmodule

`default_nettype wire

FILE: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences screen clears, input capture and result commit.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.load_in    = 1'b0;
        o_cmd.commit     = 1'b0;
        o_cmd.clear_step = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_stat.wrap ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cursor and linear position, screen RAM, clear sweep counter
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_character,
    input  wire logic [10:0] i_cell_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_cell_char,
    output logic [6:0]       o_cursor_column,
    output logic [4:0]       o_cursor_row,
    output logic             o_screen_cleared
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int LW    = $clog2(ROWS);

    logic [CW-1:0] r_col;
    logic [LW-1:0] r_line;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_clr;
    logic          r_action;
    logic [7:0]    r_char;
    logic          r_idx_ok;

    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic [6:0]    r_out_col;
    logic [4:0]    r_out_row;
    logic          r_out_clr;

    logic [CW-1:0] n_col;
    logic [LW-1:0] n_line;
    logic [AW-1:0] n_pos;
    logic [15:0]   col_x;
    logic [15:0]   line_x;
    logic [31:0]   idx_x;
    logic          is_nl;
    logic          line_inc;
    logic          wrap;
    logic          clear_done;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign idx_x      = 32'(i_cell_index);
    assign is_nl      = (r_char == NEWLINE_CHAR);
    assign line_inc   = is_nl || (r_col == CW'(COLUMNS - 1));
    assign wrap       = (r_action == ACT_PUT) && line_inc && (r_line == LW'(ROWS - 1));
    assign clear_done = (r_clr == AW'(CELLS - 1));

    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        n_pos  = r_pos;
        if (r_action == ACT_PUT) begin
            if (wrap) begin
                n_col  = '0;
                n_line = '0;
                n_pos  = '0;
            end else if (line_inc) begin
                n_col  = '0;
                n_line = r_line + 1'b1;
                n_pos  = is_nl ? (r_pos + AW'(COLUMNS) - AW'(r_col)) : (r_pos + 1'b1);
            end else begin
                n_col  = r_col + 1'b1;
                n_pos  = r_pos + 1'b1;
            end
        end
    end

    assign col_x  = 16'(n_col);
    assign line_x = 16'(n_line);

    assign ram_we    = i_cmd.clear_step ||
                       (i_cmd.commit && (r_action == ACT_PUT) && !is_nl);
    assign ram_waddr = i_cmd.clear_step ? r_clr : r_pos;
    assign ram_wdata = i_cmd.clear_step ? SPACE_CHAR : r_char;

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.load_in),
        .i_raddr (idx_x[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_line      <= '0;
            r_pos       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= clear_done ? '0 : (r_clr + 1'b1);
            end
            if (i_cmd.commit) begin
                r_col       <= n_col;
                r_line      <= n_line;
                r_pos       <= n_pos;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_char   <= i_character;
            r_idx_ok <= (idx_x < 32'(CELLS));
        end
        if (i_cmd.commit) begin
            r_out_char <= ((r_action == ACT_READ) && r_idx_ok) ? ram_rdata : 8'h00;
            r_out_col  <= col_x[6:0];
            r_out_row  <= line_x[4:0];
            r_out_clr  <= wrap;
        end
    end

    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.wrap       = wrap;
    assign o_stat.clear_done = clear_done;

    assign o_out_valid      = r_out_valid;
    assign o_cell_char      = r_out_char;
    assign o_cursor_column  = r_out_col;
    assign o_cursor_row     = r_out_row;
    assign o_screen_cleared = r_out_clr;

endmodule

`default_nettype wire

FILE: tb/text_console_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Drives put and read transactions into the text console writer with random
// bursts and gaps while the result side stalls on its own pattern. A shadow
// copy of the screen and cursor predicts every result; each result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLS        = COLUMNS_DEF;
    localparam int LINES       = ROWS_DEF;
    localparam int CELL_COUNT  = COLS * LINES;
    localparam int ITEM_TARGET = 1500;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [6:0] column;
        logic [4:0] row;
        logic       cleared;
    } t_console_result;

    typedef enum {RX_OPEN, RX_CHOPPY, RX_SLOW} t_rx_mode;

    class console_shadow;
        logic [7:0]      cells [CELL_COUNT];
        int              col;
        int              line;
        int              errors;
        t_console_result awaited[$];

        function new();
            foreach (cells[i]) cells[i] = SPACE_CHAR;
            col    = 0;
            line   = 0;
            errors = 0;
        endfunction

        function void take_item(logic act, logic [7:0] ch, logic [10:0] idx);
            t_console_result want;
            want = '0;
            if (act == ACT_READ) begin
                if (idx < CELL_COUNT) want.cell_char = cells[idx];
            end else begin
                if (ch == NEWLINE_CHAR) begin
                    col = 0;
                    line++;
                end else begin
                    cells[line * COLS + col] = ch;
                    col++;
                end
                if (col >= COLS) begin
                    col = 0;
                    line++;
                end
                if (line >= LINES) begin
                    foreach (cells[i]) cells[i] = SPACE_CHAR;
                    col          = 0;
                    line         = 0;
                    want.cleared = 1'b1;
                end
            end
            want.column = col[6:0];
            want.row    = line[4:0];
            awaited.push_back(want);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task compare_result(t_console_result got);
            t_console_result want;
            if (awaited.size() == 0) begin
                report($sformatf("result transaction with none pending: %h", got));
                return;
            end
            want = awaited.pop_front();
            if (got.cell_char !== want.cell_char)
                report($sformatf("cell_char got %h want %h", got.cell_char, want.cell_char));
            if (got.column !== want.column)
                report($sformatf("cursor_column got %0d want %0d", got.column, want.column));
            if (got.row !== want.row)
                report($sformatf("cursor_row got %0d want %0d", got.row, want.row));
            if (got.cleared !== want.cleared)
                report($sformatf("screen_cleared got %b want %b", got.cleared, want.cleared));
        endtask
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_action     = ACT_PUT;
    logic [7:0]  i_character = 8'h00;
    logic [10:0] i_cell_index = 11'd0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_cell_char;
    logic [6:0]  o_cursor_column;
    logic [4:0]  o_cursor_row;
    logic        o_screen_cleared;

    console_shadow shadow = new();
    int            burst_left  = 0;
    int            sent        = 0;
    int            cycle_count = 0;

    text_console_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_character     (i_character),
        .i_cell_index    (i_cell_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_char     (o_cell_char),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_screen_cleared(o_screen_cleared)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("text_console_writer_tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            shadow.compare_result({o_cell_char, o_cursor_column, o_cursor_row,
                                   o_screen_cleared});
    end

    // result side: phases of open flow, random chop, and slow drip
    initial begin
        t_rx_mode mode;
        int       phase_left;
        mode       = RX_OPEN;
        phase_left = 0;
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                mode       = t_rx_mode'($urandom_range(0, 2));
                phase_left = $urandom_range(5, 60);
            end
            phase_left--;
            case (mode)
                RX_OPEN: begin
                    i_out_ready <= 1'b1;
                end
                RX_CHOPPY: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_out_ready <= (phase_left % 7 == 0);
                end
            endcase
        end
    end

    task automatic send_item(input logic act, input logic [7:0] ch, input logic [10:0] idx);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 9) >= 3) gap = $urandom_range(1, 8);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_character  <= ch;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        shadow.take_item(act, ch, idx);
        burst_left--;
        sent++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_item(ACT_PUT, ch, 11'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [10:0] idx);
        send_item(ACT_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    initial begin
        int          pick;
        int          sel;
        int          len;
        int          span;
        logic [10:0] idx;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: blank screen edges, out-of-range reads, byte extremes
        read_cell(11'd0);
        read_cell(11'(CELL_COUNT - 1));
        read_cell(11'(CELL_COUNT));
        read_cell(11'h7FF);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(NEWLINE_CHAR);
        put_char(NEWLINE_CHAR);
        read_cell(11'd0);
        read_cell(11'd1);
        read_cell(11'd2);
        read_cell(11'd3);
        send_item(ACT_PUT, 8'h7E, 11'h7FF);
        read_cell(11'(2 * COLS));
        read_cell(11'(2 * COLS + 1));

        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                sel = $urandom_range(0, 19);
                if (sel < 16)
                    len = $urandom_range(0, 12);
                else if (sel < 19)
                    len = $urandom_range(70, 90);
                else
                    len = COLS;
                repeat (len) put_char(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) != 0) put_char(NEWLINE_CHAR);
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 30)) put_char(NEWLINE_CHAR);
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 6)) begin
                    span = shadow.line * COLS + shadow.col;
                    sel  = $urandom_range(0, 9);
                    if (sel < 5)
                        idx = 11'($urandom_range(0, span));
                    else if (sel < 9)
                        idx = 11'($urandom_range(0, CELL_COUNT - 1));
                    else
                        idx = 11'($urandom_range(CELL_COUNT, 2047));
                    read_cell(idx);
                end
            end else begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          11'($urandom_range(0, 2047)));
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (shadow.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (shadow.errors == 0)
            $display("text_console_writer_tb: done, clean");
        else
            $display("text_console_writer_tb: done, errors");
        $finish;
    end

endmodule
